// ===== rtl/pps_pkg.sv =====
package pps_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ARR_W      = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 10;
    localparam int TIME_W     = 21;
    localparam int RAN_SLOT_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 96;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } state_t;

    // best task seen so far, passed from cell to cell
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
    } cand_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               load_en;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic               dec_en;
        logic [SLOT_W-1:0]  dec_slot;
        logic [CNT_W-1:0]   slot_count;
        logic [TIME_W-1:0]  cur_time;
    } cell_ctl_t;

endpackage

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Load transfer: accepted only in the idle state, produces no result.
// Tick transfer: the sequencer steps through scan, calc and emit, and the result is registered
// for output in emit. One tick at a time: no new transfer is taken until that result is
// registered. The scan walks the candidate along the row of task cells, one cell per cycle.
// Reset (aresetn low, synchronous) empties the task table, clears time and done counts and
// drops any pending result; the task fields held in the cells are not cleared.
module preemptive_priority_scheduler_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] arrival_time, [31:16] burst_length, [41:32] task_priority, rest zero
    input  logic [pps_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] ran_slot, [4] finished, [25:5] completion_time, [46:26] turnaround,
    // [67:47] waiting, [68] all_done, [89:69] tick_time, rest zero
    output logic [pps_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [0] ran_valid
    output logic                          m_axis_tuser
);
    import pps_pkg::*;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]   slot_count_reg, slot_count_next;
    logic [CNT_W-1:0]   done_count_reg, done_count_next;
    logic [TIME_W-1:0]  time_reg, time_next;

    logic               found_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               fin_reg;
    logic [TIME_W-1:0]  ct_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [BURST_W-1:0] burst_reg;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg;

    cell_ctl_t ctl;
    cand_t     best;

    logic s_fire;
    logic out_free;
    logic do_load;
    logic do_emit;
    logic dec_en;
    logic calc_fin;
    logic [TIME_W-1:0] calc_ct;
    logic [TIME_W-1:0] wt;
    logic [SLOT_W+RAN_SLOT_W-1:0] slot_ext;
    logic [RAN_SLOT_W-1:0] ran_slot;
    logic [TIME_W-1:0] ct_o, tat_o, wt_o;
    logic all_done;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign do_load  = s_fire && (s_axis_tuser == CMD_LOAD) && (slot_count_reg < CNT_W'(SLOTS));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && (s_axis_tuser == CMD_TICK)) state_next = ST_SCAN;
            ST_SCAN: if (scan_cnt_reg == SLOT_W'(SLOTS - 1)) state_next = ST_CALC;
            ST_CALC: state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        dec_en        = 1'b0;
        do_emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: ;
            ST_CALC: dec_en = best.found;
            ST_EMIT: do_emit = out_free;
            default: ;
        endcase
    end

    always_comb begin
        ctl.load_en    = do_load;
        ctl.arrival    = s_axis_tdata[15:0];
        ctl.burst      = s_axis_tdata[31:16];
        ctl.prio       = s_axis_tdata[41:32];
        ctl.dec_en     = dec_en;
        ctl.dec_slot   = best.slot;
        ctl.slot_count = slot_count_reg;
        ctl.cur_time   = time_reg;
    end

    pps_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .best    (best)
    );

    assign calc_fin = best.found && (best.remaining == BURST_W'(1));
    assign calc_ct  = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_W'(1);

    always_comb begin
        scan_cnt_next   = (state_reg == ST_SCAN) ? scan_cnt_reg + SLOT_W'(1) : '0;
        slot_count_next = slot_count_reg + CNT_W'(do_load);
        done_count_next = done_count_reg;
        if (do_load && (s_axis_tdata[31:16] == '0)) begin
            // zero burst is done at load
            done_count_next = done_count_reg + CNT_W'(1);
        end else if ((state_reg == ST_CALC) && calc_fin) begin
            done_count_next = done_count_reg + CNT_W'(1);
        end
        time_next = time_reg;
        if (do_emit && (time_reg != TIME_MAX)) begin
            time_next = time_reg + TIME_W'(1);
        end
        m_valid_next = m_valid_reg;
        if (do_emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            slot_count_reg <= '0;
            done_count_reg <= '0;
            time_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            slot_count_reg <= slot_count_next;
            done_count_reg <= done_count_next;
            time_reg       <= time_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // winner snapshot, first half of the timing math
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            found_reg <= best.found;
            slot_reg  <= best.slot;
            fin_reg   <= calc_fin;
            ct_reg    <= calc_ct;
            tat_reg   <= calc_ct - TIME_W'(best.arrival);
            burst_reg <= best.burst;
        end
    end

    // waiting floors at zero once completion time has saturated
    assign wt = (tat_reg >= TIME_W'(burst_reg)) ? tat_reg - TIME_W'(burst_reg) : '0;

    assign slot_ext = {RAN_SLOT_W'(0), slot_reg};
    assign ran_slot = found_reg ? slot_ext[RAN_SLOT_W-1:0] : '0;
    assign ct_o     = fin_reg ? ct_reg : '0;
    assign tat_o    = fin_reg ? tat_reg : '0;
    assign wt_o     = fin_reg ? wt : '0;
    assign all_done = done_count_reg == slot_count_reg;

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            m_user_reg <= found_reg;
            m_data_reg <= {6'd0, time_reg, all_done, wt_o, tat_o, ct_o, fin_reg, ran_slot};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_done_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        done_count_reg <= slot_count_reg)
        else $error("more tasks done than loaded");

    a_winner_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) && best.found |-> CNT_W'(best.slot) < slot_count_reg)
        else $error("winner slot beyond loaded tasks");

    a_fin_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) && calc_fin |=> done_count_reg == $past(done_count_reg) + CNT_W'(1))
        else $error("finished task not counted");

    a_time_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_emit |=> time_reg == $past(time_reg))
        else $error("time moved outside a tick result");

endmodule

// ===== rtl/pps_cell.sv =====
module pps_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pps_pkg::SLOT_W-1:0] cell_idx,
    input  pps_pkg::cell_ctl_t        ctl,
    input  pps_pkg::cand_t            cand_in,
    output pps_pkg::cand_t            cand_out
);
    import pps_pkg::*;

    logic [ARR_W-1:0]   arrival_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [BURST_W-1:0] remaining_reg;
    cand_t              cand_reg;
    cand_t              cand_next;
    cand_t              own;
    logic               here;
    logic               eligible;
    logic               better;

    assign here = CNT_W'(cell_idx) == ctl.slot_count;

    assign eligible = (CNT_W'(cell_idx) < ctl.slot_count)
                    && (TIME_W'(arrival_reg) <= ctl.cur_time)
                    && (remaining_reg != '0);

    // strict compare keeps the earlier slot on equal priority
    assign better = eligible && (!cand_in.found || (prio_reg < cand_in.prio));

    always_comb begin
        own.found     = 1'b1;
        own.slot      = cell_idx;
        own.prio      = prio_reg;
        own.arrival   = arrival_reg;
        own.burst     = burst_reg;
        own.remaining = remaining_reg;
        cand_next     = better ? own : cand_in;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_en && here) begin
            arrival_reg   <= ctl.arrival;
            burst_reg     <= ctl.burst;
            prio_reg      <= ctl.prio;
            remaining_reg <= ctl.burst;
        end else if (ctl.dec_en && (ctl.dec_slot == cell_idx)) begin
            remaining_reg <= remaining_reg - BURST_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
        end else begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

// ===== rtl/pps_chain.sv =====
module pps_chain (
    input  logic               aclk,
    input  logic               aresetn,
    input  pps_pkg::cell_ctl_t ctl,
    output pps_pkg::cand_t     best
);
    import pps_pkg::*;

    cand_t link [SLOTS+1];

    assign link[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        pps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(i)),
            .ctl      (ctl),
            .cand_in  (link[i]),
            .cand_out (link[i+1])
        );
    end

    assign best = link[SLOTS];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    localparam int RANDOM_ITEMS = 1030;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [S_DATA_W-1:0] data;
        logic                cmd;
        int                  phase;
    } sched_item_t;

    typedef struct packed {
        logic                  ran_valid;
        logic [RAN_SLOT_W-1:0] ran_slot;
        logic                  finished;
        logic [TIME_W-1:0]     completion;
        logic [TIME_W-1:0]     turnaround;
        logic [TIME_W-1:0]     waiting;
        logic                  all_done;
        logic [TIME_W-1:0]     tick_time;
    } tick_report_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    preemptive_priority_scheduler_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // task table mirror
    logic [ARR_W-1:0]   task_arrival   [SLOTS];
    logic [BURST_W-1:0] task_burst     [SLOTS];
    logic [PRIO_W-1:0]  task_prio      [SLOTS];
    logic [BURST_W-1:0] task_remaining [SLOTS];
    int                 tasks_loaded;
    int                 tasks_done;
    logic [TIME_W-1:0]  sched_now;

    sched_item_t  stim_q[$];
    tick_report_t tick_expect_q[$];

    int  cur_phase;
    bit  s_took;
    int  mismatches;
    int  unexpected;
    int  loads_seen;
    int  dropped_loads;
    int  ticks_seen;
    int  reports_checked;
    int  completions_seen;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int idle_pct(int phase, bit receiver);
        case (phase)
            1:       return receiver ? 0 : 54;
            2:       return receiver ? 54 : 0;
            3:       return 30;
            default: return 0;
        endcase
    endfunction

    task automatic push_load(logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst,
                             logic [PRIO_W-1:0] prio, int phase);
        sched_item_t it;
        it.cmd   = CMD_LOAD;
        it.data  = {6'b0, prio, burst, arr};
        it.phase = phase;
        stim_q.push_back(it);
    endtask

    task automatic push_tick(int phase);
        sched_item_t it;
        it.cmd   = CMD_TICK;
        // fields are don't-care on a tick, so fill them with junk
        it.data  = {6'b0, 10'($urandom), 16'($urandom), 16'($urandom)};
        it.phase = phase;
        stim_q.push_back(it);
    endtask

    // applies one accepted transfer to the mirrored scheduler state
    task automatic advance_schedule(logic [S_DATA_W-1:0] data, logic cmd);
        bit                found;
        int                best;
        logic [PRIO_W-1:0] best_prio;
        tick_report_t      rep;
        if (cmd == CMD_LOAD) begin
            if (tasks_loaded >= SLOTS) begin
                dropped_loads++;
                return;
            end
            task_arrival[tasks_loaded]   = data[15:0];
            task_burst[tasks_loaded]     = data[31:16];
            task_prio[tasks_loaded]      = data[41:32];
            task_remaining[tasks_loaded] = data[31:16];
            if (data[31:16] == 0)
                tasks_done++;
            tasks_loaded++;
            loads_seen++;
            return;
        end
        found     = 1'b0;
        best      = 0;
        best_prio = '0;
        rep       = '0;
        for (int i = 0; i < tasks_loaded; i++) begin
            if (TIME_W'(task_arrival[i]) <= sched_now && task_remaining[i] != 0) begin
                if (!found || task_prio[i] < best_prio) begin
                    found     = 1'b1;
                    best      = i;
                    best_prio = task_prio[i];
                end
            end
        end
        if (found) begin
            rep.ran_valid = 1'b1;
            rep.ran_slot  = RAN_SLOT_W'(best);
            task_remaining[best]--;
            if (task_remaining[best] == 0) begin
                rep.finished   = 1'b1;
                rep.completion = (sched_now < TIME_MAX) ? sched_now + 1'b1 : TIME_MAX;
                rep.turnaround = rep.completion - TIME_W'(task_arrival[best]);
                rep.waiting    = (rep.turnaround >= TIME_W'(task_burst[best])) ?
                                 rep.turnaround - TIME_W'(task_burst[best]) : '0;
                tasks_done++;
            end
        end
        rep.all_done  = (tasks_done == tasks_loaded);
        rep.tick_time = sched_now;
        if (sched_now < TIME_MAX)
            sched_now++;
        ticks_seen++;
        tick_expect_q.push_back(rep);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (stim_q.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(stim_q[0].phase, 1'b0)) begin
                s_axis_tdata  <= stim_q[0].data;
                s_axis_tuser  <= stim_q[0].cmd;
                cur_phase     = stim_q[0].phase;
                s_axis_tvalid <= 1'b1;
                void'(stim_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b1));
    end

    // monitor: check results, then predict from accepted input transfers
    always @(posedge aclk) begin
        tick_report_t got;
        tick_report_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.ran_valid  = m_axis_tuser;
            got.ran_slot   = m_axis_tdata[3:0];
            got.finished   = m_axis_tdata[4];
            got.completion = m_axis_tdata[25:5];
            got.turnaround = m_axis_tdata[46:26];
            got.waiting    = m_axis_tdata[67:47];
            got.all_done   = m_axis_tdata[68];
            got.tick_time  = m_axis_tdata[89:69];
            if (tick_expect_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing pending", $realtime);
            end else begin
                want = tick_expect_q.pop_front();
                reports_checked++;
                if (got.finished === 1'b1)
                    completions_seen++;
                if (got.ran_valid !== want.ran_valid || got.ran_slot !== want.ran_slot ||
                    got.finished !== want.finished || got.completion !== want.completion ||
                    got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
                    got.all_done !== want.all_done || got.tick_time !== want.tick_time) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS) begin
                        $display("%0t: tick %0d mismatch", $realtime, want.tick_time);
                        $display("  exp: run=%0d slot=%0d fin=%0d ct=%0d tat=%0d wt=%0d done=%0d t=%0d",
                                 want.ran_valid, want.ran_slot, want.finished, want.completion,
                                 want.turnaround, want.waiting, want.all_done, want.tick_time);
                        $display("  got: run=%0d slot=%0d fin=%0d ct=%0d tat=%0d wt=%0d done=%0d t=%0d",
                                 got.ran_valid, got.ran_slot, got.finished, got.completion,
                                 got.turnaround, got.waiting, got.all_done, got.tick_time);
                    end
                end
            end
        end
        s_took <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            advance_schedule(s_axis_tdata, s_axis_tuser);
    end

    initial begin
        int counted;
        int gen_loaded;
        int gen_ticks;
        int phase;
        int arr;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        m_axis_tready = 1'b0;
        s_took        = 1'b0;
        cur_phase     = 0;
        tasks_loaded  = 0;
        tasks_done    = 0;
        sched_now     = '0;
        mismatches    = 0;
        unexpected    = 0;
        loads_seen    = 0;
        dropped_loads = 0;
        ticks_seen    = 0;
        reports_checked  = 0;
        completions_seen = 0;

        // directed: idle tick on an empty table
        push_tick(0);
        // equal priorities resolve to the lower slot
        push_load(16'd0, 16'd2, 10'd5, 0);
        push_load(16'd0, 16'd2, 10'd5, 0);
        // future arrival with top priority takes over when it arrives
        push_load(16'd3, 16'd1, 10'd0, 0);
        // zero burst counts as done at load
        push_load(16'd0, 16'd0, 10'd998, 0);
        // run everything out, then idle ticks with all_done set
        repeat (7) push_tick(0);
        // late load with arrival in the past and the largest priority value
        push_load(16'd0, 16'd3, 10'd1023, 0);
        push_load(16'hFFFF, 16'hFFFF, 10'd0, 0);
        push_load(16'd0, 16'hFFFF, 10'd1023, 0);
        repeat (5) push_tick(0);

        gen_loaded = 7;
        gen_ticks  = 13;
        counted    = 0;
        while (counted < RANDOM_ITEMS) begin
            phase = counted * 4 / RANDOM_ITEMS;
            if (gen_loaded < SLOTS && $urandom_range(0, 99) < 2) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_load(16'($urandom), 16'($urandom_range(1, 65535)),
                              10'($urandom), phase);
                end else begin
                    arr = gen_ticks + $urandom_range(0, 50);
                    if (arr > 65535)
                        arr = 65535;
                    push_load(16'(arr), 16'($urandom_range(1, 80)),
                              $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                   : 10'($urandom_range(0, 1023)), phase);
                end
                gen_loaded++;
                counted++;
            end else if (gen_loaded >= SLOTS && $urandom_range(0, 149) == 0) begin
                // table full: dropped by the block
                push_load(16'($urandom), 16'($urandom), 10'($urandom), phase);
            end else begin
                push_tick(phase);
                gen_ticks++;
                counted++;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (tick_expect_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Covered %0d task loads (%0d dropped on a full table) and %0d ticks.",
                 loads_seen, dropped_loads, ticks_seen);
        $display("Checked %0d tick reports, %0d with a completion; %0d mismatches, %0d stray.",
                 reports_checked, completions_seen, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && tick_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d reports outstanding.", tick_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
